[rtl/deadline_timer_queue_core_assert.svh]
// Assertion macros for the timer queue core
`ifndef DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_CORE_ASSERT_SVH
// Check an implication on every clock edge outside reset
`define DTQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check an implication in the next cycle
`define DTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and codes shared by the timer queue core and its cells.
// ----------------------------------------------------------------------------
package dtq_pkg;
  localparam int TimeW = 48;
  localparam int PerW  = 32;
  localparam int IdW   = 16;
  localparam int MaxFire = 16;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_ADD1 = 3'd1;
  localparam logic [2:0] OP_ADDP = 3'd2;
  localparam logic [2:0] OP_CANC = 3'd3;
  localparam logic [2:0] OP_CLR  = 3'd4;

  localparam logic [2:0] K_FIRED = 3'd0;
  localparam logic [2:0] K_ADDED = 3'd1;
  localparam logic [2:0] K_FULL  = 3'd2;
  localparam logic [2:0] K_CANC  = 3'd3;
  localparam logic [2:0] K_NOTF  = 3'd4;
  localparam logic [2:0] K_CLR   = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] amount;
    logic [15:0] target_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] entry_id;
    logic [4:0]  occupancy;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [PerW-1:0]  period;
    logic [IdW-1:0]   ident;
  } entry_t;

  // Chain command broadcast to all cells
  typedef struct packed {
    logic ins;      // insert the broadcast entry in sorted place
    logic pop;      // shift everything one place towards the head
    logic rm;       // remove the first cell whose ident matches
    logic clr;      // drop every entry
  } cmd_t;
endpackage

[rtl/dtq_cell.sv]
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted chain: holds an entry, takes from its neighbours.
// ----------------------------------------------------------------------------
module dtq_cell (
  input  logic            clk,
  input  logic            rst,
  input  dtq_pkg::cmd_t   cmd,
  input  dtq_pkg::entry_t bcast,
  input  logic            prev_valid,
  input  logic            prev_goes,   // insert lands at or before the previous cell
  input  logic            prev_hit,    // a match lies at or before the previous cell
  input  dtq_pkg::entry_t prev_entry,
  input  logic            nxt_valid,
  input  dtq_pkg::entry_t nxt_entry,
  output logic            valid,
  output logic            goes,
  output logic            hit,
  output dtq_pkg::entry_t entry
);
  logic mine_goes;
  logic mine_hit;

  // Insert goes before the first entry whose deadline is not smaller
  assign mine_goes = !valid || (entry.deadline >= bcast.deadline);
  assign goes      = prev_goes || mine_goes;
  assign mine_hit  = valid && (entry.ident == bcast.ident);
  assign hit       = prev_hit || mine_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (prev_goes) begin
        valid <= prev_valid;
        entry <= prev_entry;
      end else if (mine_goes) begin
        valid <= 1'b1;
        entry <= bcast;
      end
    end else if (cmd.pop || (cmd.rm && hit)) begin
      valid <= nxt_valid;
      entry <= nxt_entry;
    end
  end
endmodule

[rtl/deadline_timer_queue_core.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// Deadline-sorted timer table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// One transaction at a time, taken only while the sequencer is idle. An add,
// cancel or clear passes through accept, chain update and result load, with
// its result made valid at the result load; an unused opcode is dropped after
// its accept with no result. A tick passes through accept and a head check,
// then per fired entry a pop and a result load, and a periodic entry's rearm
// takes a further chain step; at most 16 entries fire per tick. Results pass
// from a staging register into the output register, and the sequencer waits
// at a result load only while the output register still holds an untaken
// result, so the next transaction may be accepted while a result waits.
`include "deadline_timer_queue_core_assert.svh"
module deadline_timer_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dtq_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        run_enable;
  logic [dtq_pkg::TimeW-1:0] current_time;
  logic [dtq_pkg::IdW-1:0]   next_ident;
  logic [CW-1:0] held;
  logic [4:0]  fired;
  dtq_pkg::in_t  req;
  dtq_pkg::cmd_t cmd;
  dtq_pkg::entry_t bcast;
  logic [2:0]  res_kind;
  logic [15:0] res_id;
  logic        res_last;
  logic        any_hit;
  logic        load_out;

  logic            cv   [DEPTH];
  logic            cg   [DEPTH];
  logic            ch   [DEPTH];
  dtq_pkg::entry_t ce   [DEPTH];

  // Build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic            pv, pg, ph, nv;
    dtq_pkg::entry_t pe, ne;
    if (g == 0) begin : g_first
      assign pv = 1'b0;
      assign pg = 1'b0;
      assign ph = 1'b0;
      assign pe = bcast;
    end else begin : g_mid
      assign pv = cv[g-1];
      assign pg = cg[g-1];
      assign ph = ch[g-1];
      assign pe = ce[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign ne = ce[g];
    end else begin : g_inner
      assign nv = cv[g+1];
      assign ne = ce[g+1];
    end
    dtq_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .bcast(bcast),
      .prev_valid(pv), .prev_goes(pg), .prev_hit(ph), .prev_entry(pe),
      .nxt_valid(nv), .nxt_entry(ne),
      .valid(cv[g]), .goes(cg[g]), .hit(ch[g]), .entry(ce[g])
    );
  end

  assign any_hit  = ch[DEPTH-1];
  assign in_ready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = {31'd0, run_enable};
  assign load_out = ((state == S_WAIT) || (state == S_EMIT)) && (!out_valid || out_ready);

  // Decide the chain command for this cycle
  always_comb begin
    cmd   = '0;
    bcast = '0;
    bcast.ident = req.target_id;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_EMIT;
        unique case (req.opcode)
          dtq_pkg::OP_ADD1, dtq_pkg::OP_ADDP: begin
            cmd.ins = (held < CW'(DEPTH));
            bcast.ident = next_ident;
            if (req.opcode == dtq_pkg::OP_ADD1) begin
              bcast.deadline = current_time + dtq_pkg::TimeW'(req.amount);
              bcast.period   = '0;
            end else begin
              bcast.deadline = current_time;
              bcast.period   = (req.amount == '0) ? 32'd1 : req.amount;
            end
          end
          dtq_pkg::OP_CANC: cmd.rm  = 1'b1;
          dtq_pkg::OP_CLR:  cmd.clr = 1'b1;
          dtq_pkg::OP_TICK: state_next = S_HEAD;
          default: state_next = S_IDLE;
        endcase
      end
      S_HEAD: begin
        if (run_enable && cv[0] && ce[0].deadline <= current_time
            && fired != 5'(dtq_pkg::MaxFire)) begin
          cmd.pop = 1'b1;
          state_next = (ce[0].period != '0) ? S_FIRE : S_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIRE: begin
        cmd.ins = 1'b1;
        bcast.deadline = current_time + dtq_pkg::TimeW'(req.amount);
        bcast.period   = req.amount;
        bcast.ident    = req.target_id;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid || out_ready) state_next = S_HEAD;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequence control and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_enable   <= 1'b1;
      current_time <= '0;
      next_ident   <= 16'd1;
      held         <= '0;
      fired        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr == 2'd0) run_enable <= pwdata[0];
      // Load the output register from staging, or drop a taken result
      if (load_out) begin
        out_valid <= 1'b1;
        out_data  <= '{kind: res_kind, entry_id: res_id, occupancy: 5'(held),
                       last: res_last};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            fired <= '0;
            if (in_data.opcode == dtq_pkg::OP_TICK) current_time <= current_time + 1'b1;
          end
        end
        S_EXEC: begin
          res_last <= 1'b1;
          unique case (req.opcode)
            dtq_pkg::OP_ADD1, dtq_pkg::OP_ADDP: begin
              if (held < CW'(DEPTH)) begin
                res_kind <= dtq_pkg::K_ADDED;
                res_id   <= next_ident;
                held     <= held + 1'b1;
                next_ident <= (next_ident == 16'hFFFF) ? 16'd1 : next_ident + 1'b1;
              end else begin
                res_kind <= dtq_pkg::K_FULL;
                res_id   <= '0;
              end
            end
            dtq_pkg::OP_CANC: begin
              res_kind <= any_hit ? dtq_pkg::K_CANC : dtq_pkg::K_NOTF;
              res_id   <= req.target_id;
              if (any_hit) held <= held - 1'b1;
            end
            dtq_pkg::OP_CLR: begin
              res_kind <= dtq_pkg::K_CLR;
              res_id   <= '0;
              held     <= '0;
            end
            default: begin
              res_kind <= dtq_pkg::K_FIRED;
              res_id   <= req.target_id;
            end
          endcase
        end
        S_HEAD: begin
          if (cmd.pop) begin
            res_kind <= dtq_pkg::K_FIRED;
            res_id   <= ce[0].ident;
            fired    <= fired + 1'b1;
            // Hold the popped entry for rearm in the request register
            req.amount    <= ce[0].period;
            req.target_id <= ce[0].ident;
            if (ce[0].period == '0) held <= held - 1'b1;
            // Last if nothing further can fire
            res_last <= (fired == 5'(dtq_pkg::MaxFire - 1)) ||
                        (ce[0].period == '0 ?
                          !(cv[1 % DEPTH] && DEPTH > 1 && ce[1 % DEPTH].deadline <= current_time)
                          : 1'b0);
          end
        end
        S_FIRE: begin
          // Last once the burst limit is reached or neither new head nor rearm is due
          res_last <= (fired == 5'(dtq_pkg::MaxFire)) ||
                      !((cv[0] && ce[0].deadline <= current_time) ||
                        bcast.deadline <= current_time);
        end
        default: ;
      endcase
    end
  end

  `DTQ_ASSERT_IMP(a_held_bound, 1'b1, held <= CW'(DEPTH))
  `DTQ_ASSERT_IMP(a_ready_idle, in_ready, state == S_IDLE)
  `DTQ_ASSERT_NEXT(a_clear_empties, state == S_EXEC && req.opcode == dtq_pkg::OP_CLR,
                   held == '0 && !cv[0])
  `DTQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadline-sorted timer queue core. Walks a short
// table of directed requests and a full-table burst, then random traffic
// under several idling mixes, and checks every result against a behavioural
// copy of the timer table kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  localparam int TableDepth = 16;
  localparam int CycleLimit = 3000000;
  localparam logic [1:0] ADDR_RUN_ENABLE = 2'd0;
  localparam logic [2:0] OP_UNUSED = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    dtq_pkg::in_t  item;
    bit            typed;
    dtq_pkg::out_t res;
  } row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  dtq_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  dtq_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [1:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Bench copy of the timer table
  logic [47:0] tq_deadline [TableDepth];
  logic [31:0] tq_period [TableDepth];
  logic [15:0] tq_ident [TableDepth];
  int          tq_held;
  logic [47:0] tq_now;
  logic [15:0] tq_next_id;
  logic        tq_run;

  dtq_pkg::out_t expected_results[$];
  row_t directed_rows[$];
  int   errors = 0;
  int   results_seen = 0;
  int   requests_sent = 0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_stall = 0;

  deadline_timer_queue_core #(.DEPTH(TableDepth)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Drop the entry at pos and close the gap
  function void tq_remove(int pos);
    for (int i = pos; i + 1 < tq_held; i++) begin
      tq_deadline[i] = tq_deadline[i+1];
      tq_period[i]   = tq_period[i+1];
      tq_ident[i]    = tq_ident[i+1];
    end
    tq_held--;
  endfunction

  // Insert ahead of the first entry whose deadline is not smaller
  function void tq_place(logic [47:0] dl, logic [31:0] per, logic [15:0] id);
    int pos;
    pos = 0;
    while (pos < tq_held && tq_deadline[pos] < dl) pos++;
    for (int i = tq_held; i > pos; i--) begin
      tq_deadline[i] = tq_deadline[i-1];
      tq_period[i]   = tq_period[i-1];
      tq_ident[i]    = tq_ident[i-1];
    end
    tq_deadline[pos] = dl;
    tq_period[pos]   = per;
    tq_ident[pos]    = id;
    tq_held++;
  endfunction

  function dtq_pkg::out_t tq_result(logic [2:0] kind, logic [15:0] id);
    dtq_pkg::out_t r;
    r.kind = kind;
    r.entry_id = id;
    r.occupancy = 5'(tq_held);
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the table by one request and collect the results it causes
  function automatic void timer_model_step(dtq_pkg::in_t x, ref dtq_pkg::out_t res[$]);
    logic [15:0] id;
    logic [31:0] per;
    int pos;
    res.delete();
    case (x.opcode)
      dtq_pkg::OP_TICK: begin
        tq_now = tq_now + 48'd1;
        if (tq_run) begin
          while (res.size() < dtq_pkg::MaxFire && tq_held > 0 && tq_deadline[0] <= tq_now) begin
            id = tq_ident[0];
            per = tq_period[0];
            tq_remove(0);
            if (per != 0) tq_place(tq_now + 48'(per), per, id);
            res.push_back(tq_result(dtq_pkg::K_FIRED, id));
          end
        end
      end
      dtq_pkg::OP_ADD1, dtq_pkg::OP_ADDP: begin
        if (tq_held >= TableDepth) begin
          res.push_back(tq_result(dtq_pkg::K_FULL, 16'd0));
        end else begin
          id = tq_next_id;
          tq_next_id = tq_next_id + 16'd1;
          if (tq_next_id == 16'd0) tq_next_id = 16'd1;
          if (x.opcode == dtq_pkg::OP_ADD1) tq_place(tq_now + 48'(x.amount), 32'd0, id);
          else tq_place(tq_now, (x.amount == 0) ? 32'd1 : x.amount, id);
          res.push_back(tq_result(dtq_pkg::K_ADDED, id));
        end
      end
      dtq_pkg::OP_CANC: begin
        pos = 0;
        while (pos < tq_held && tq_ident[pos] != x.target_id) pos++;
        if (pos < tq_held) begin
          tq_remove(pos);
          res.push_back(tq_result(dtq_pkg::K_CANC, x.target_id));
        end else begin
          res.push_back(tq_result(dtq_pkg::K_NOTF, x.target_id));
        end
      end
      dtq_pkg::OP_CLR: begin
        tq_held = 0;
        res.push_back(tq_result(dtq_pkg::K_CLR, 16'd0));
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  function dtq_pkg::in_t make_req(logic [2:0] op, logic [31:0] amt, logic [15:0] tid);
    dtq_pkg::in_t x;
    x.opcode = op;
    x.amount = amt;
    x.target_id = tid;
    return x;
  endfunction

  function void add_row(logic [2:0] op, logic [31:0] amt, logic [15:0] tid, bit typed,
                        logic [2:0] kind, logic [15:0] id, logic [4:0] occ);
    row_t r;
    r.item = make_req(op, amt, tid);
    r.typed = typed;
    r.res = '{kind: kind, entry_id: id, occupancy: occ, last: 1'b1};
    directed_rows.push_back(r);
  endfunction

  // Hand one request to the core, then book what it should produce
  task automatic push_request(dtq_pkg::in_t x, bit typed = 1'b0, dtq_pkg::out_t typed_res = '0);
    dtq_pkg::out_t res[$];
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    timer_model_step(x, res);
    if (typed) expected_results.push_back(typed_res);
    else foreach (res[i]) expected_results.push_back(res[i]);
    requests_sent++;
  endtask

  // Hold off until the core has drained, then let any quiet tick finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_run_enable(logic v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_RUN_ENABLE;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tq_run = v;
    // Read back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== v) begin
      errors++;
      if (errors <= 10) $display("run_enable readback: expected %0b, got %0b", v, prdata[0]);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function dtq_pkg::in_t random_req();
    int pick;
    dtq_pkg::in_t x;
    pick = $urandom_range(99);
    x.amount = $urandom();
    x.target_id = 16'($urandom());
    if (pick < 40) begin
      x.opcode = dtq_pkg::OP_TICK;
    end else if (pick < 65) begin
      x.opcode = dtq_pkg::OP_ADD1;
      if ($urandom_range(9) != 0) x.amount = $urandom_range(25);
    end else if (pick < 80) begin
      x.opcode = dtq_pkg::OP_ADDP;
      if ($urandom_range(9) != 0) x.amount = $urandom_range(12);
    end else if (pick < 93) begin
      x.opcode = dtq_pkg::OP_CANC;
      if (tq_held > 0 && $urandom_range(9) < 7) x.target_id = tq_ident[$urandom_range(tq_held-1)];
    end else if (pick < 96) begin
      x.opcode = dtq_pkg::OP_CLR;
    end else begin
      x.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED));
    end
    return x;
  endfunction

  // Receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data.kind !== expected_results[0].kind ||
            out_data.entry_id !== expected_results[0].entry_id ||
            out_data.occupancy !== expected_results[0].occupancy ||
            out_data.last !== expected_results[0].last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", expected_results[0], out_data);
        end
        expected_results.delete(0);
      end
    end
  end

  initial begin
    tq_held = 0;
    tq_now = '0;
    tq_next_id = 16'd1;
    tq_run = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_run_enable(1'b1);

    // Directed table
    add_row(dtq_pkg::OP_TICK, 32'd0, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);   // quiet tick
    add_row(dtq_pkg::OP_CANC, 32'd0, 16'd5, 1, dtq_pkg::K_NOTF, 16'd5, 5'd0);    // unknown cancel
    add_row(dtq_pkg::OP_ADD1, 32'd0, 16'd0, 1, dtq_pkg::K_ADDED, 16'd1, 5'd1);
    add_row(dtq_pkg::OP_TICK, 32'd0, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_ADDP, 32'd0, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);   // zero period
    add_row(dtq_pkg::OP_ADDP, 32'hFFFF_FFFF, 16'hFFFF, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_ADD1, 32'hFFFF_FFFF, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_ADD1, 32'd3, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_ADD1, 32'd3, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);   // equal deadline
    for (int i = 0; i < 4; i++)
      add_row(dtq_pkg::OP_TICK, 32'd0, 16'd0, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_CANC, 32'd0, 16'd3, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(OP_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF, 0, dtq_pkg::K_FIRED, 16'd0, 5'd0);
    add_row(dtq_pkg::OP_CLR, 32'd0, 16'd0, 1, dtq_pkg::K_CLR, 16'd0, 5'd0);
    foreach (directed_rows[i]) push_request(directed_rows[i].item, directed_rows[i].typed,
                                            directed_rows[i].res);

    // Fill the table, overflow it, then fire a full burst
    for (int i = 0; i < TableDepth; i++)
      push_request(make_req(dtq_pkg::OP_ADDP, 32'd1, 16'd0));
    push_request(make_req(dtq_pkg::OP_ADD1, 32'd1, 16'd0), 1'b1,
                 '{kind: dtq_pkg::K_FULL, entry_id: 16'd0, occupancy: 5'd16, last: 1'b1});
    push_request(make_req(dtq_pkg::OP_TICK, 32'd0, 16'd0));
    push_request(make_req(dtq_pkg::OP_CLR, 32'd0, 16'd0));
    settle();

    // Random traffic under four idling mixes, with firing held off in part of one
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      for (int i = 0; i < 110; i++) begin
        if (ph == 2 && (i == 40 || i == 80)) begin
          settle();
          write_run_enable(i == 40 ? 1'b0 : 1'b1);
        end
        push_request(random_req());
      end
      settle();
    end

    // Drain and report
    send_idle = 0;
    recv_stall = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d results: directed rows, full table, burst,",
             requests_sent, results_seen);
    $display("random mixes under sender and receiver stalls, firing paused and resumed");
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
